/* src/lbda_pkg.sv */
`default_nettype none

package lbda_pkg;

  // Limits of the block
  localparam int MAX_OUT_COLUMNS = 1024;
  localparam int MAX_BLOCK       = 64;
  localparam int MAX_IMAGE_WIDTH = 4096;
  localparam int SHADE_COUNT     = 8;

  // Field and counter widths
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int BLK_W      = 7;
  localparam int CIB_W      = 6;
  localparam int OCOL_W     = 11;
  localparam int IDX_W      = 10;
  localparam int LVL_W      = 3;
  localparam int CHAR_W     = 7;
  localparam int LUMA_W     = 18;
  localparam int RBS_W      = 24;
  localparam int ACC_W      = 30;
  localparam int AREA_W     = 13;
  localparam int UNIT_W     = 27;
  localparam int THR_N      = SHADE_COUNT - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Luma weights in thousandths, and one shade step (32 units) in thousandths
  localparam int LUMA_R    = 299;
  localparam int LUMA_G    = 587;
  localparam int LUMA_B    = 114;
  localparam int SHADE_STEP = 32000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd4;

  // Geometry derived from the configuration
  typedef struct packed {
    logic                              busy;
    logic [DIM_W-1:0]                  w;
    logic [DIM_W-1:0]                  h;
    logic [BLK_W-1:0]                  bw;
    logic [BLK_W-1:0]                  bh;
    logic                              invert;
    logic [OCOL_W-1:0]                 ocols;
    logic [DIM_W-1:0]                  span_w;
    logic [DIM_W-1:0]                  span_h;
    logic [THR_N-1:0][ACC_W-1:0]       thr;
  } geom_t;

  // Block-row segment finished by a pixel, sent to the column accumulator
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [RBS_W-1:0]  part;
    logic              rend;
    logic              fend;
  } req_t;

  // Completed block sum
  typedef struct packed {
    logic              valid;
    logic [ACC_W-1:0]  acc;
    logic              rend;
    logic              fend;
  } res_t;

  // Shade characters, dark to light
  function automatic logic [CHAR_W-1:0] shade_char(input logic [LVL_W-1:0] sel);
    logic [CHAR_W-1:0] c;
    case (sel)
      3'd0: c = 7'd64;   // '@'
      3'd1: c = 7'd35;   // '#'
      3'd2: c = 7'd37;   // '%'
      3'd3: c = 7'd42;   // '*'
      3'd4: c = 7'd124;  // '|'
      3'd5: c = 7'd45;   // '-'
      3'd6: c = 7'd46;   // '.'
      default: c = 7'd32;  // ' '
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/lbda_if.sv */
`default_nettype none

// Pixel request channel
interface lbda_pix_if;
  logic                        valid;
  logic                        ready;
  logic [lbda_pkg::PIX_W-1:0]  red;
  logic [lbda_pkg::PIX_W-1:0]  green;
  logic [lbda_pkg::PIX_W-1:0]  blue;
  logic                        frame_start;

  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

// Character request channel
interface lbda_char_if;
  logic                         valid;
  logic                         ready;
  logic [lbda_pkg::CHAR_W-1:0]  char_code;
  logic [lbda_pkg::LVL_W-1:0]   shade_level;
  logic                         row_end;
  logic                         frame_end;

  modport source (output valid, char_code, shade_level, row_end, frame_end, input ready);
  modport sink   (input valid, char_code, shade_level, row_end, frame_end, output ready);
endinterface

`default_nettype wire

/* src/lbda_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle
module lbda_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lbda_pkg::DIM_W-1:0]    dividend,
  input  wire logic [lbda_pkg::BLK_W-1:0]    divisor,
  output logic                               done,
  output logic [lbda_pkg::DIM_W-1:0]         quotient,
  output logic [lbda_pkg::BLK_W-1:0]         remainder
);

  localparam int CNT_W = $clog2(lbda_pkg::DIM_W);

  logic [lbda_pkg::DIM_W-1:0] quo_r;
  logic [lbda_pkg::BLK_W-1:0] rem_r;
  logic [lbda_pkg::BLK_W-1:0] dvs_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r;
  logic                       done_r;
  logic [lbda_pkg::BLK_W:0]   trial;
  logic                       ge;
  logic                       last_step;

  // Shift in the next dividend bit and try a subtract
  assign trial     = {rem_r, quo_r[lbda_pkg::DIM_W-1]};
  assign ge        = trial >= {1'b0, dvs_r};
  assign last_step = cnt_r == CNT_W'(lbda_pkg::DIM_W - 1);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r & last_step;
      if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last_step) run_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[lbda_pkg::DIM_W-2:0], ge};
      rem_r <= ge ? lbda_pkg::BLK_W'(trial - {1'b0, dvs_r})
                  : trial[lbda_pkg::BLK_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* src/lbda_cfg.sv */
`default_nettype none

// Configuration registers and derived geometry
module lbda_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [lbda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbda_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lbda_pkg::geom_t                        geom
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] S_DIVW_GO = 4'd1;
  localparam logic [ST_W-1:0] S_DIVW    = 4'd2;
  localparam logic [ST_W-1:0] S_DIVH_GO = 4'd3;
  localparam logic [ST_W-1:0] S_DIVH    = 4'd4;
  localparam logic [ST_W-1:0] S_SPAN    = 4'd5;
  localparam logic [ST_W-1:0] S_AREA    = 4'd6;
  localparam logic [ST_W-1:0] S_SCALE   = 4'd7;
  localparam logic [ST_W-1:0] S_THR     = 4'd8;

  localparam int DIM_W  = lbda_pkg::DIM_W;
  localparam int BLK_W  = lbda_pkg::BLK_W;
  localparam int ACC_W  = lbda_pkg::ACC_W;
  localparam int THR_CW = $clog2(lbda_pkg::THR_N);

  // Raw registers
  logic [DIM_W-1:0] iw_r, ih_r;
  logic [BLK_W-1:0] ibw_r, ibh_r;
  logic             inv_r;

  // Clamped sizes
  logic [DIM_W-1:0] w_c, h_c;
  logic [BLK_W-1:0] bw_c, bh_c;

  // Sequencer and derived values
  logic [ST_W-1:0]                         state_r, state_nxt;
  logic [lbda_pkg::OCOL_W-1:0]             ocols_r;
  logic [DIM_W-1:0]                        span_w_r, span_h_r;
  logic [lbda_pkg::AREA_W-1:0]             area_r;
  logic [lbda_pkg::UNIT_W-1:0]             unit_r;
  logic [ACC_W-1:0]                        thr_acc_r, thr_acc_nxt;
  logic [lbda_pkg::THR_N-1:0][ACC_W-1:0]   thr_r;
  logic [THR_CW-1:0]                       thr_cnt_r;

  logic                     div_start, div_done;
  logic [DIM_W-1:0]         div_a, div_q;
  logic [BLK_W-1:0]         div_b, div_rem;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r  <= DIM_W'(640);
      ih_r  <= DIM_W'(480);
      ibw_r <= BLK_W'(8);
      ibh_r <= BLK_W'(8);
      inv_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbda_pkg::REG_IMAGE_WIDTH:  iw_r  <= cfg_data;
        lbda_pkg::REG_IMAGE_HEIGHT: ih_r  <= cfg_data;
        lbda_pkg::REG_BLOCK_WIDTH:  ibw_r <= cfg_data[BLK_W-1:0];
        lbda_pkg::REG_BLOCK_HEIGHT: ibh_r <= cfg_data[BLK_W-1:0];
        lbda_pkg::REG_INVERT:       inv_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Zero reads as one, oversize saturates
  always_comb begin
    w_c  = (iw_r == '0) ? DIM_W'(1) :
           (iw_r > DIM_W'(lbda_pkg::MAX_IMAGE_WIDTH)) ? DIM_W'(lbda_pkg::MAX_IMAGE_WIDTH) : iw_r;
    h_c  = (ih_r == '0) ? DIM_W'(1) :
           (ih_r > DIM_W'(lbda_pkg::MAX_IMAGE_WIDTH)) ? DIM_W'(lbda_pkg::MAX_IMAGE_WIDTH) : ih_r;
    bw_c = (ibw_r == '0) ? BLK_W'(1) :
           (ibw_r > BLK_W'(lbda_pkg::MAX_BLOCK)) ? BLK_W'(lbda_pkg::MAX_BLOCK) : ibw_r;
    bh_c = (ibh_r == '0) ? BLK_W'(1) :
           (ibh_r > BLK_W'(lbda_pkg::MAX_BLOCK)) ? BLK_W'(lbda_pkg::MAX_BLOCK) : ibh_r;
  end

  // Shared divider: blocks per row, then rows per frame
  assign div_start = (state_r == S_DIVW_GO) || (state_r == S_DIVH_GO);
  assign div_a     = (state_r == S_DIVW_GO) ? w_c : h_c;
  assign div_b     = (state_r == S_DIVW_GO) ? bw_c : bh_c;

  lbda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign thr_acc_nxt = thr_acc_r + ACC_W'(unit_r);

  // Sequencer; any write restarts it
  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = S_DIVW_GO;
    end else begin
      unique case (state_r)
        S_IDLE:    state_nxt = S_IDLE;
        S_DIVW_GO: state_nxt = S_DIVW;
        S_DIVW:    if (div_done) state_nxt = S_DIVH_GO;
        S_DIVH_GO: state_nxt = S_DIVH;
        S_DIVH:    if (div_done) state_nxt = S_SPAN;
        S_SPAN:    state_nxt = S_AREA;
        S_AREA:    state_nxt = S_SCALE;
        S_SCALE:   state_nxt = S_THR;
        S_THR:     if (thr_cnt_r == THR_CW'(lbda_pkg::THR_N - 1)) state_nxt = S_IDLE;
        default:   state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DIVW_GO;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Derived values, one step per state
  always_ff @(posedge clk) begin
    if (state_r == S_DIVW && div_done) begin
      ocols_r <= (div_q > DIM_W'(lbda_pkg::MAX_OUT_COLUMNS)) ?
                 lbda_pkg::OCOL_W'(lbda_pkg::MAX_OUT_COLUMNS) :
                 div_q[lbda_pkg::OCOL_W-1:0];
    end
    if (state_r == S_DIVH && div_done) begin
      span_h_r <= h_c - DIM_W'(div_rem);
    end
    if (state_r == S_SPAN) begin
      span_w_r <= DIM_W'(ocols_r) * DIM_W'(bw_c);
    end
    if (state_r == S_AREA) begin
      area_r <= lbda_pkg::AREA_W'(bw_c) * lbda_pkg::AREA_W'(bh_c);
    end
    if (state_r == S_SCALE) begin
      unit_r    <= lbda_pkg::UNIT_W'(area_r) * lbda_pkg::UNIT_W'(lbda_pkg::SHADE_STEP);
      thr_acc_r <= '0;
      thr_cnt_r <= '0;
    end
    // Thresholds k * step * area, one per cycle
    if (state_r == S_THR) begin
      thr_acc_r          <= thr_acc_nxt;
      thr_r[thr_cnt_r]   <= thr_acc_nxt;
      thr_cnt_r          <= thr_cnt_r + THR_CW'(1);
    end
  end

  always_comb begin
    geom.busy   = state_r != S_IDLE;
    geom.w      = w_c;
    geom.h      = h_c;
    geom.bw     = bw_c;
    geom.bh     = bh_c;
    geom.invert = inv_r;
    geom.ocols  = ocols_r;
    geom.span_w = span_w_r;
    geom.span_h = span_h_r;
    geom.thr    = thr_r;
  end

endmodule

`default_nettype wire

/* src/lbda_colmem.sv */
`default_nettype none

// Per-column sum memory with read-modify-write stage
module lbda_colmem (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lbda_pkg::req_t  req,
  output lbda_pkg::res_t       res,
  output logic                 clr_busy
);

  localparam int ACC_W = lbda_pkg::ACC_W;
  localparam int IDX_W = lbda_pkg::IDX_W;

  logic [ACC_W-1:0] sums_mem [lbda_pkg::MAX_OUT_COLUMNS];

  logic                     b_valid_r;
  logic                     b_first_r, b_last_r, b_rend_r, b_fend_r;
  logic [IDX_W-1:0]         b_idx_r;
  logic [lbda_pkg::RBS_W-1:0] b_part_r;
  logic [ACC_W-1:0]         rd_data_r;
  logic                     fwd_hit_r;
  logic [ACC_W-1:0]         fwd_data_r;
  logic [IDX_W:0]           clr_cnt_r;

  logic                     rd_en;
  logic                     wr_en;
  logic [ACC_W-1:0]         b_old;
  logic [ACC_W-1:0]         b_acc;

  // First row of a band starts from zero, so no read is needed
  assign rd_en    = req.valid & ~req.first;
  assign wr_en    = b_valid_r & ~b_last_r;
  assign clr_busy = ~clr_cnt_r[IDX_W];

  // Old sum: forwarded write when the same column was written last cycle
  assign b_old = b_first_r ? '0 : (fwd_hit_r ? fwd_data_r : rd_data_r);
  assign b_acc = b_old + ACC_W'(b_part_r);

  // Stage control and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      b_valid_r <= req.valid;
      if (clr_busy) clr_cnt_r <= clr_cnt_r + (IDX_W+1)'(1);
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (req.valid) begin
      b_first_r <= req.first;
      b_last_r  <= req.last;
      b_idx_r   <= req.idx;
      b_part_r  <= req.part;
      b_rend_r  <= req.rend;
      b_fend_r  <= req.fend;
    end
    if (rd_en) begin
      fwd_hit_r  <= wr_en && (b_idx_r == req.idx);
      fwd_data_r <= b_acc;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      sums_mem[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (wr_en) begin
      sums_mem[b_idx_r] <= b_acc;
    end
    if (rd_en) begin
      rd_data_r <= sums_mem[req.idx];
    end
  end

  always_comb begin
    res.valid = b_valid_r & b_last_r;
    res.acc   = b_acc;
    res.rend  = b_rend_r;
    res.fend  = b_fend_r;
  end

endmodule

`default_nettype wire

/* src/luma_box_downscale_to_ascii.sv */
`default_nettype none

// A character follows the pixel that completes its block through the column memory
// stage, the level stage and the output register. Throughput: up to one pixel per
// cycle; input pauses while two characters are in flight, while the column memory
// is cleared and while the geometry is derived. Reset clears every memory entry
// and derives the geometry (two 13-step divisions); every config write re-runs it.
module luma_box_downscale_to_ascii (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lbda_pix_if.sink                               in_pix,
  lbda_char_if.source                            out_char,
  input  wire logic                              cfg_we,
  input  wire logic [lbda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lbda_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POS_W  = lbda_pkg::POS_W;
  localparam int DIM_W  = lbda_pkg::DIM_W;
  localparam int CIB_W  = lbda_pkg::CIB_W;
  localparam int BLK_W  = lbda_pkg::BLK_W;
  localparam int OCOL_W = lbda_pkg::OCOL_W;
  localparam int RBS_W  = lbda_pkg::RBS_W;
  localparam int LUMA_W = lbda_pkg::LUMA_W;
  localparam int ACC_W  = lbda_pkg::ACC_W;
  localparam int LVL_W  = lbda_pkg::LVL_W;

  lbda_pkg::geom_t geom;
  lbda_pkg::req_t  req;
  lbda_pkg::res_t  res;
  logic            clr_busy;

  // Position state
  logic [POS_W-1:0]  pc_r, pc_nxt, pc;
  logic [POS_W-1:0]  pr_r, pr_nxt, pr;
  logic [CIB_W-1:0]  cib_r, cib_nxt, cib;
  logic [CIB_W-1:0]  rib_r, rib_nxt, rib;
  logic [OCOL_W-1:0] oc_r, oc_nxt, oc;
  logic [RBS_W-1:0]  rbs_r, rbs_nxt, rbs;

  logic              accept;
  logic [LUMA_W-1:0] luma;
  logic [RBS_W-1:0]  rbs_sum;
  logic              in_rng, blk_end, row_last, rend, col_end, row_wrap, band_last;

  // Level stage and output register
  logic              c_valid_r, c_rend_r, c_fend_r;
  logic [ACC_W-1:0]  c_acc_r;
  logic              c_move;
  logic [lbda_pkg::THR_N-1:0] ge_v;
  logic [LVL_W-1:0]  lvl, sel;
  logic              o_valid_r, o_rend_r, o_fend_r;
  logic [lbda_pkg::CHAR_W-1:0] o_char_r;
  logic [LVL_W-1:0]  o_lvl_r;
  logic [1:0]        occ;

  lbda_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  lbda_colmem u_colmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .res      (res),
    .clr_busy (clr_busy)
  );

  // Input gating: at most two characters in flight
  assign occ          = 2'(res.valid) + 2'(c_valid_r) + 2'(o_valid_r);
  assign in_pix.ready = ~geom.busy & ~clr_busy & (occ < 2'd2);
  assign accept       = in_pix.valid & in_pix.ready;

  // Frame start clears the position before the pixel is used
  always_comb begin
    pc  = in_pix.frame_start ? '0 : pc_r;
    pr  = in_pix.frame_start ? '0 : pr_r;
    cib = in_pix.frame_start ? '0 : cib_r;
    rib = in_pix.frame_start ? '0 : rib_r;
    oc  = in_pix.frame_start ? '0 : oc_r;
    rbs = in_pix.frame_start ? '0 : rbs_r;
  end

  // Luma in thousandths
  assign luma = LUMA_W'(in_pix.red)   * LUMA_W'(lbda_pkg::LUMA_R)
              + LUMA_W'(in_pix.green) * LUMA_W'(lbda_pkg::LUMA_G)
              + LUMA_W'(in_pix.blue)  * LUMA_W'(lbda_pkg::LUMA_B);
  assign rbs_sum = rbs + RBS_W'(luma);

  // Position decisions
  assign in_rng    = (DIM_W'(pc) < geom.span_w) && (oc < geom.ocols)
                     && (DIM_W'(pr) < geom.span_h);
  assign blk_end   = (BLK_W'(cib) + BLK_W'(1)) >= geom.bw;
  assign row_last  = (BLK_W'(rib) + BLK_W'(1)) >= geom.bh;
  assign rend      = ((OCOL_W+1)'(oc) + (OCOL_W+1)'(1)) >= (OCOL_W+1)'(geom.ocols);
  assign band_last = (DIM_W'(pr) + DIM_W'(1)) >= geom.span_h;
  assign col_end   = (DIM_W'(pc) + DIM_W'(1)) >= geom.w;
  assign row_wrap  = (DIM_W'(pr) + DIM_W'(1)) >= geom.h;

  // Request to the column memory on each finished block-row segment
  always_comb begin
    req.valid = accept & in_rng & blk_end;
    req.first = rib == '0;
    req.last  = row_last;
    req.idx   = oc[lbda_pkg::IDX_W-1:0];
    req.part  = rbs_sum;
    req.rend  = rend;
    req.fend  = rend & band_last;
  end

  // Next position
  always_comb begin
    pc_nxt  = pc;
    pr_nxt  = pr;
    cib_nxt = cib;
    rib_nxt = rib;
    oc_nxt  = oc;
    rbs_nxt = rbs;
    if (in_rng) begin
      if (blk_end) begin
        rbs_nxt = '0;
        cib_nxt = '0;
        oc_nxt  = oc + OCOL_W'(1);
      end else begin
        rbs_nxt = rbs_sum;
        cib_nxt = cib + CIB_W'(1);
      end
    end
    if (col_end) begin
      pc_nxt  = '0;
      cib_nxt = '0;
      oc_nxt  = '0;
      rbs_nxt = '0;
      rib_nxt = row_last ? '0 : rib + CIB_W'(1);
      if (row_wrap) begin
        pr_nxt  = '0;
        rib_nxt = '0;
      end else begin
        pr_nxt = pr + POS_W'(1);
      end
    end else begin
      pc_nxt = pc + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      pr_r  <= '0;
      cib_r <= '0;
      rib_r <= '0;
      oc_r  <= '0;
      rbs_r <= '0;
    end else if (accept) begin
      pc_r  <= pc_nxt;
      pr_r  <= pr_nxt;
      cib_r <= cib_nxt;
      rib_r <= rib_nxt;
      oc_r  <= oc_nxt;
      rbs_r <= rbs_nxt;
    end
  end

  // Level: how many thresholds the block sum reaches
  always_comb begin
    lvl = '0;
    for (int k = 0; k < lbda_pkg::THR_N; k++) begin
      ge_v[k] = c_acc_r >= geom.thr[k];
      lvl     = lvl + LVL_W'(ge_v[k]);
    end
    sel = geom.invert ? (LVL_W'(lbda_pkg::THR_N) - lvl) : lvl;
  end

  assign c_move = c_valid_r & (~o_valid_r | out_char.ready);

  // Stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      c_valid_r <= res.valid | (c_valid_r & ~c_move);
      if (c_move) begin
        o_valid_r <= 1'b1;
      end else if (out_char.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      c_acc_r  <= res.acc;
      c_rend_r <= res.rend;
      c_fend_r <= res.fend;
    end
    if (c_move) begin
      o_char_r <= lbda_pkg::shade_char(sel);
      o_lvl_r  <= lvl;
      o_rend_r <= c_rend_r;
      o_fend_r <= c_fend_r;
    end
  end

  assign out_char.valid       = o_valid_r;
  assign out_char.char_code   = o_char_r;
  assign out_char.shade_level = o_lvl_r;
  assign out_char.row_end     = o_rend_r;
  assign out_char.frame_end   = o_fend_r;

  // Never more than two characters in flight
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.valid && c_valid_r && o_valid_r))
    else $error("three characters in flight");

  // A finished block always finds room in the level stage
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (!c_valid_r || c_move))
    else $error("level stage overrun");

  // Last character of a frame closes its row
  a_fend: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_fend_r) |-> o_rend_r)
    else $error("frame end without row end");

  // No pixel taken while memory is cleared or geometry recomputed
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_busy || geom.busy) |-> !req.valid)
    else $error("pixel accepted while busy");

endmodule

`default_nettype wire

/* tb/sv/luma_box_downscale_to_ascii_tb.sv */
module luma_box_downscale_to_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W           = lbda_pkg::PIX_W;
  localparam int CHAR_W          = lbda_pkg::CHAR_W;
  localparam int LVL_W           = lbda_pkg::LVL_W;
  localparam int DIM_W           = lbda_pkg::DIM_W;
  localparam int BLK_W           = lbda_pkg::BLK_W;
  localparam int ACC_W           = lbda_pkg::ACC_W;
  localparam int POS_W           = lbda_pkg::POS_W;
  localparam int CIB_W           = lbda_pkg::CIB_W;
  localparam int OCOL_W          = lbda_pkg::OCOL_W;
  localparam int RBS_W           = lbda_pkg::RBS_W;
  localparam int CFG_IDX_W       = lbda_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = lbda_pkg::CFG_DATA_W;
  localparam int SHADE_COUNT     = lbda_pkg::SHADE_COUNT;
  localparam int MAX_OUT_COLUMNS = lbda_pkg::MAX_OUT_COLUMNS;
  localparam int MAX_IMAGE_WIDTH = lbda_pkg::MAX_IMAGE_WIDTH;
  localparam int MAX_BLOCK       = lbda_pkg::MAX_BLOCK;
  localparam int LUMA_R          = lbda_pkg::LUMA_R;
  localparam int LUMA_G          = lbda_pkg::LUMA_G;
  localparam int LUMA_B          = lbda_pkg::LUMA_B;
  localparam int SHADE_STEP      = lbda_pkg::SHADE_STEP;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_ITEMS = 150;
  localparam int          QUIET_AFTER  = 100;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          MAX_REPORTS  = 40;
  localparam int          HOLD_CYCLES  = 400;

  // Shade characters dark to light, entry 0 in the low bits
  localparam logic [SHADE_COUNT*CHAR_W-1:0] SHADE_CHARS =
    {7'd32, 7'd46, 7'd45, 7'd124, 7'd42, 7'd37, 7'd35, 7'd64};

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_start;
  } pixel_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [LVL_W-1:0]  shade_level;
    logic              row_end;
    logic              frame_end;
  } shade_t;

  typedef enum {STYLE_RANDOM, STYLE_GRAY, STYLE_EXTREME, STYLE_EDGE} pix_style_t;
  typedef enum {FRAME_WHOLE, FRAME_CUT, FRAME_NO_START, FRAME_STRAY_START} frame_kind_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbda_pix_if  in_pix ();
  lbda_char_if out_char ();

  luma_box_downscale_to_ascii u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_char (out_char),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shared run state
  shade_t      expected_shades[$];
  int unsigned error_count   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned shades_seen   = 0;
  int unsigned configs_run   = 0;
  int unsigned cycle_count   = 0;
  int unsigned random_sent   = 0;
  int unsigned hold_left     = 0;
  bit          idle_on       = 1'b1;

  // Predictor copy of the registers and the position state
  logic [DIM_W-1:0]  reg_image_w;
  logic [DIM_W-1:0]  reg_image_h;
  logic [BLK_W-1:0]  reg_block_w;
  logic [BLK_W-1:0]  reg_block_h;
  logic              reg_invert;
  logic [ACC_W-1:0]  column_acc [MAX_OUT_COLUMNS];
  logic [POS_W-1:0]  at_col;
  logic [POS_W-1:0]  at_row;
  logic [CIB_W-1:0]  col_in_blk;
  logic [CIB_W-1:0]  row_in_blk;
  logic [OCOL_W-1:0] blk_col;
  logic [RBS_W-1:0]  seg_sum;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d characters still pending",
             cycle_count, expected_shades.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic pixel_t make_pixel(input logic [PIX_W-1:0] r, g, b, input logic fs);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.frame_start = fs;
    return px;
  endfunction

  function automatic pixel_t next_pixel(input pix_style_t style);
    logic [PIX_W-1:0] g;
    pixel_t px;
    case (style)
      STYLE_GRAY: begin
        g = PIX_W'($urandom_range(0, 255));
        px = make_pixel(g, g, g, 1'b0);
      end
      STYLE_EXTREME: begin
        px = make_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00,
                        $urandom_range(0, 1) ? 8'hFF : 8'h00,
                        $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
      end
      STYLE_EDGE: begin
        // gray right at or just below a level threshold
        g = PIX_W'($urandom_range(1, 7) * 32 - $urandom_range(0, 1));
        px = make_pixel(g, g, g, 1'b0);
      end
      default: begin
        px = make_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b0);
      end
    endcase
    return px;
  endfunction

  // Predictor: advance the position state by one accepted pixel
  task automatic predict_pixel(input pixel_t px);
    int unsigned w, h, bw, bh, ocols, orows, luma, idx;
    longint unsigned level, sel;
    logic [ACC_W-1:0] acc;
    shade_t want;
    w  = clamp_size(reg_image_w, MAX_IMAGE_WIDTH);
    h  = clamp_size(reg_image_h, MAX_IMAGE_WIDTH);
    bw = clamp_size(reg_block_w, MAX_BLOCK);
    bh = clamp_size(reg_block_h, MAX_BLOCK);
    ocols = w / bw;
    orows = h / bh;
    if (ocols > MAX_OUT_COLUMNS) ocols = MAX_OUT_COLUMNS;

    if (px.frame_start) begin
      at_col = '0;
      at_row = '0;
      col_in_blk = '0;
      row_in_blk = '0;
      blk_col = '0;
      seg_sum = '0;
    end

    // accumulate only inside whole blocks
    if (at_col < ocols * bw && blk_col < ocols && at_row < orows * bh) begin
      luma = LUMA_R * px.red + LUMA_G * px.green + LUMA_B * px.blue;
      seg_sum = seg_sum + luma;
      if (col_in_blk + 1 >= bw) begin
        idx = blk_col % MAX_OUT_COLUMNS;
        acc = ((row_in_blk == 0) ? '0 : column_acc[idx]) + seg_sum;
        if (row_in_blk + 1 >= bh) begin
          level = longint'(acc) / (longint'(SHADE_STEP) * bw * bh);
          if (level > SHADE_COUNT - 1) level = SHADE_COUNT - 1;
          sel = reg_invert ? (SHADE_COUNT - 1 - level) : level;
          want.char_code   = SHADE_CHARS[sel*CHAR_W +: CHAR_W];
          want.shade_level = LVL_W'(level);
          want.row_end     = (blk_col + 1 >= ocols);
          want.frame_end   = want.row_end && (at_row + 1 >= orows * bh);
          expected_shades.push_back(want);
        end else begin
          column_acc[idx] = acc;
        end
        seg_sum = '0;
        col_in_blk = '0;
        blk_col = blk_col + 1;
      end else begin
        col_in_blk = col_in_blk + 1;
      end
    end

    // raster position, wrapping to the top past the last row
    if (at_col + 1 >= w) begin
      at_col = '0;
      col_in_blk = '0;
      blk_col = '0;
      seg_sum = '0;
      row_in_blk = (row_in_blk + 1 >= bh) ? '0 : row_in_blk + 1;
      if (at_row + 1 >= h) begin
        at_row = '0;
        row_in_blk = '0;
      end else begin
        at_row = at_row + 1;
      end
    end else begin
      at_col = at_col + 1;
    end
  endtask

  // Pixel request sender
  task automatic send_pixel(input pixel_t px);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_pix.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_pix.valid       <= 1'b1;
    in_pix.red         <= px.red;
    in_pix.green       <= px.green;
    in_pix.blue        <= px.blue;
    in_pix.frame_start <= px.frame_start;
    @(posedge clk);
    while (in_pix.ready !== 1'b1) @(posedge clk);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // Stream of mixed pixels, frame start on the first one
  task automatic send_stream(input int unsigned count);
    pixel_t px;
    for (int unsigned k = 0; k < count; k++) begin
      px = next_pixel(pix_style_t'($urandom_range(0, 3)));
      px.frame_start = (k == 0);
      send_pixel(px);
    end
  endtask

  // Wait until all characters are out and the pipeline has drained
  task automatic settle_block();
    in_pix.valid <= 1'b0;
    while (expected_shades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_pix.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lbda_pkg::REG_IMAGE_WIDTH:  reg_image_w = val;
      lbda_pkg::REG_IMAGE_HEIGHT: reg_image_h = val;
      lbda_pkg::REG_BLOCK_WIDTH:  reg_block_w = val[BLK_W-1:0];
      lbda_pkg::REG_BLOCK_HEIGHT: reg_block_h = val[BLK_W-1:0];
      lbda_pkg::REG_INVERT:       reg_invert  = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] iw, ih, bw, bh, inv);
    settle_block();
    write_reg(lbda_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(lbda_pkg::REG_IMAGE_HEIGHT, ih);
    write_reg(lbda_pkg::REG_BLOCK_WIDTH, bw);
    write_reg(lbda_pkg::REG_BLOCK_HEIGHT, bh);
    write_reg(lbda_pkg::REG_INVERT, inv);
    cfg_we <= 1'b0;
    configs_run++;
  endtask

  // Zero sizes act as 1x1 blocks: one character per pixel, every level and both tables
  task automatic test_level_sweep();
    configure(0, 0, 0, 0, 0);
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
    send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'd31, 8'd31, 8'd31, 1'b0));
    for (int g = 32; g < 256; g += 32)
      send_pixel(make_pixel(PIX_W'(g), PIX_W'(g), PIX_W'(g), 1'b0));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    configure(0, 0, 0, 0, 1);
    for (int g = 0; g < 256; g += 32)
      send_pixel(make_pixel(PIX_W'(g), PIX_W'(g), PIX_W'(g), 1'b0));
  endtask

  // Image narrower than a block, then leftover columns and rows dropped
  task automatic test_partial_blocks();
    configure(3, 2, 4, 1, 0);
    send_stream(6);
    configure(7, 5, 2, 2, 1);
    send_stream(35);
  endtask

  // More block columns than the column memory holds
  task automatic test_wide_row();
    configure(1030, 1, 0, 1, 0);
    send_stream(1030);
  endtask

  // Register values above the limits saturate; upper bits of block sizes are ignored
  task automatic test_oversize();
    configure(13'h1FFF, 1, 13'h1FFF, 1, 0);
    send_stream(MAX_BLOCK + 4);
    configure(1, 13'h1FFF, 1, 13'h007F, 1);
    send_stream(MAX_BLOCK + 4);
  endtask

  // Receiver holds off while pixels keep coming, so the input must stall
  task automatic test_backpressure();
    configure(1, 1, 1, 1, 0);
    idle_on = 1'b0;
    hold_left = HOLD_CYCLES;
    send_stream(40);
    idle_on = 1'b1;
  endtask

  // Random settings with mostly whole frames, some cut, unmarked or with stray starts
  task automatic test_random_frames();
    int unsigned fw, fh, frames, len;
    logic [CFG_DATA_W-1:0] iw, ih, bw, bh;
    frame_kind_t kind;
    pix_style_t style;
    bit wide, flat;
    pixel_t flat_px, px;
    while (random_sent < RANDOM_ITEMS) begin
      wide = ($urandom_range(0, 7) == 0);
      iw = ($urandom_range(0, 15) == 0) ? 13'd0 :
           wide ? CFG_DATA_W'($urandom_range(64, 200)) : CFG_DATA_W'($urandom_range(1, 24));
      ih = wide ? CFG_DATA_W'($urandom_range(1, 3)) : CFG_DATA_W'($urandom_range(0, 12));
      bw = wide ? CFG_DATA_W'($urandom_range(8, 64)) : CFG_DATA_W'($urandom_range(0, 7));
      bh = wide ? CFG_DATA_W'($urandom_range(1, 2)) : CFG_DATA_W'($urandom_range(0, 5));
      // junk above the 7-bit block size fields
      if ($urandom_range(0, 5) == 0) bw = bw | CFG_DATA_W'($urandom_range(1, 63) << BLK_W);
      if ($urandom_range(0, 5) == 0) bh = bh | CFG_DATA_W'($urandom_range(1, 63) << BLK_W);
      idle_on = (random_sent < QUIET_AFTER);
      configure(iw, ih, bw, bh, CFG_DATA_W'($urandom_range(0, 1)));
      fw = clamp_size(reg_image_w, MAX_IMAGE_WIDTH);
      fh = clamp_size(reg_image_h, MAX_IMAGE_WIDTH);
      frames = wide ? 1 : $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        case ($urandom_range(0, 9))
          0:       kind = FRAME_CUT;
          1:       kind = FRAME_NO_START;
          2:       kind = FRAME_STRAY_START;
          default: kind = FRAME_WHOLE;
        endcase
        len = (kind == FRAME_CUT) ? $urandom_range(1, fw * fh) : fw * fh;
        flat = ($urandom_range(0, 3) == 0);
        flat_px = next_pixel(STYLE_EDGE);
        style = pix_style_t'($urandom_range(0, 3));
        for (int unsigned k = 0; k < len; k++) begin
          if (random_sent >= RANDOM_ITEMS) break;
          // no idling on either side in the closing stretch
          idle_on = (random_sent < QUIET_AFTER);
          px = flat ? flat_px : next_pixel(style);
          px.frame_start = (k == 0 && kind != FRAME_NO_START) ||
                           (kind == FRAME_STRAY_START && $urandom_range(0, 15) == 0);
          send_pixel(px);
          random_sent++;
        end
      end
    end
  endtask

  // Character request receiver and checker
  initial begin : char_sink
    shade_t want;
    int unsigned stall_left;
    stall_left = 0;
    out_char.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_char.valid === 1'b1 && out_char.ready === 1'b1) begin
        shades_seen++;
        if (expected_shades.size() == 0) begin
          report_mismatch($sformatf("unexpected character %0d", out_char.char_code));
        end else begin
          want = expected_shades.pop_front();
          if (out_char.char_code !== want.char_code)
            report_mismatch($sformatf("char_code got %0d want %0d",
                                      out_char.char_code, want.char_code));
          if (out_char.shade_level !== want.shade_level)
            report_mismatch($sformatf("shade_level got %0d want %0d",
                                      out_char.shade_level, want.shade_level));
          if (out_char.row_end !== want.row_end)
            report_mismatch($sformatf("row_end got %b want %b",
                                      out_char.row_end, want.row_end));
          if (out_char.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end got %b want %b",
                                      out_char.frame_end, want.frame_end));
        end
      end
      // long hold first, then random stall bursts
      if (hold_left > 0) begin
        out_char.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_char.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_char.ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_char.ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    rst_n              <= 1'b0;
    in_pix.valid       <= 1'b0;
    in_pix.red         <= '0;
    in_pix.green       <= '0;
    in_pix.blue        <= '0;
    in_pix.frame_start <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= lbda_pkg::REG_IMAGE_WIDTH;
    cfg_data           <= '0;

    // predictor matches the reset state
    reg_image_w = 13'd640;
    reg_image_h = 13'd480;
    reg_block_w = 7'd8;
    reg_block_h = 7'd8;
    reg_invert  = 1'b0;
    foreach (column_acc[i]) column_acc[i] = '0;
    at_col = '0;
    at_row = '0;
    col_in_blk = '0;
    row_in_blk = '0;
    blk_col = '0;
    seg_sum = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_level_sweep();
    test_partial_blocks();
    test_wide_row();
    test_oversize();
    test_backpressure();
    test_random_frames();

    in_pix.valid <= 1'b0;
    while (expected_shades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (expected_shades.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", expected_shades.size()));

    $display("Sent %0d pixel requests over %0d register settings, checked %0d characters,",
             pixels_sent, configs_run, shades_seen);
    $display("covering all levels, both shade tables, clamped sizes, wide rows and a long stall.");
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", error_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* luma_box_downscale_to_ascii.f */
src/lbda_pkg.sv
src/lbda_if.sv
src/lbda_div.sv
src/lbda_cfg.sv
src/lbda_colmem.sv
src/luma_box_downscale_to_ascii.sv
tb/sv/luma_box_downscale_to_ascii_tb.sv
